@@ rtl/opl_pkg.sv @@
// Shared types, widths and operation codes for the online perceptron learner.
// No dependencies; imported by every module of the block.
package opl_pkg;

    localparam int MAX_FEATURES  = 8;
    localparam int FEAT_W        = 16;
    localparam int WEIGHT_W      = 32;
    localparam int RATE_W        = 16;
    localparam int PROD_W        = WEIGHT_W + FEAT_W;
    localparam int DELTA_W       = RATE_W + 1 + FEAT_W;
    localparam int UPD_W         = DELTA_W + 1;
    localparam int OP_W          = 2;
    localparam int IDX_W         = 4;
    localparam int PRED_W        = 2;

    localparam logic [RATE_W-1:0]          RATE_RESET   = 16'hFFFF;
    localparam logic signed [FEAT_W-1:0]   BIAS_FEATURE = 16'sd256;

    localparam logic [OP_W-1:0] OP_TRAIN   = 2'd0;
    localparam logic [OP_W-1:0] OP_PREDICT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    localparam logic signed [PRED_W-1:0] PRED_POS  = 2'sb01;
    localparam logic signed [PRED_W-1:0] PRED_NEG  = 2'sb11;
    localparam logic signed [PRED_W-1:0] PRED_ZERO = 2'sb00;

    typedef struct packed {
        logic pos;
        logic neg;
    } score_sign_t;

    typedef struct packed {
        logic load;
        logic commit;
        logic clear;
        logic positive;
    } lane_ctrl_t;

endpackage

@@ rtl/opl_lane.sv @@
// One weight lane: holds a weight, forms weight*feature and rate*feature,
// and applies the saturating update. Depends on opl_pkg.
module opl_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  opl_pkg::lane_ctrl_t                 ctrl,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature,
    input  logic [opl_pkg::RATE_W-1:0]          learning_rate,
    output logic signed [opl_pkg::PROD_W-1:0]   product,
    output logic signed [opl_pkg::WEIGHT_W-1:0] weight,
    output logic                                clip
);
    import opl_pkg::*;

    logic signed [WEIGHT_W-1:0] weight_reg, weight_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic signed [UPD_W-1:0]    sum;
    logic signed [WEIGHT_W-1:0] sat_val;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg  <= PROD_W'(weight_reg) * PROD_W'(feature);
            delta_reg <= DELTA_W'($signed({1'b0, learning_rate})) * DELTA_W'(feature);
        end
    end

    always_comb
    begin
        if (ctrl.positive)
            sum = UPD_W'(weight_reg) + UPD_W'(delta_reg);
        else
            sum = UPD_W'(weight_reg) - UPD_W'(delta_reg);
        clip = (sum[UPD_W-1:WEIGHT_W-1] != '0) && (sum[UPD_W-1:WEIGHT_W-1] != '1);
        if (!clip)
            sat_val = sum[WEIGHT_W-1:0];
        else if (sum[UPD_W-1])
            sat_val = {1'b1, {(WEIGHT_W-1){1'b0}}};
        else
            sat_val = {1'b0, {(WEIGHT_W-1){1'b1}}};
        if (ctrl.clear)
            weight_next = '0;
        else if (ctrl.commit)
            weight_next = sat_val;
        else
            weight_next = weight_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weight_reg <= '0;
        else
            weight_reg <= weight_next;
    end

    assign product = prod_reg;
    assign weight  = weight_reg;

endmodule

@@ rtl/opl_merge.sv @@
// Merge stage: sums the lane products into the exact score and gives its sign.
// Depends on opl_pkg.
module opl_merge #(
    parameter int LANES = opl_pkg::MAX_FEATURES + 1
) (
    input  logic signed [opl_pkg::PROD_W-1:0] products [LANES],
    output opl_pkg::score_sign_t              sign
);
    import opl_pkg::*;

    localparam int SCORE_W = PROD_W + $clog2(LANES + 1);

    logic signed [SCORE_W-1:0] score;

    always_comb
    begin
        score = '0;
        for (int i = 0; i < LANES; i++)
            score = score + SCORE_W'(products[i]);
        sign.neg = score[SCORE_W-1];
        sign.pos = !score[SCORE_W-1] && (score != '0);
    end

endmodule

@@ rtl/online_perceptron_learner.sv @@
// Top level of the online perceptron learner: request/result handshakes,
// weight lanes and merge stage. Depends on opl_pkg, opl_lane, opl_merge.
//
//   channel   signals                               accepted when
//   input     in_valid, in_ready, op .. feature_7   in_valid & in_ready
//   result    out_valid, out_ready, prediction ..   out_valid & out_ready
//   config    cfg_wr_en, cfg_wr_data                cfg_wr_en
//
// Products are registered in the lanes, then score sum, sign and weight
// update follow. Predict and read requests issue every cycle unless results
// stall; a train or clear request blocks the next one while weights settle.
// Reset zeroes the weights and sets the rate to its maximum. A stalled result
// holds in the output register while one more request waits in the lanes.
module online_perceptron_learner #(
    parameter int FEATURE_COUNT = opl_pkg::MAX_FEATURES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [opl_pkg::RATE_W-1:0]          cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [opl_pkg::OP_W-1:0]            op,
    input  logic                                label_positive,
    input  logic [opl_pkg::IDX_W-1:0]           weight_index,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_0,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_1,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_2,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_3,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_4,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_5,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_6,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_7,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [opl_pkg::PRED_W-1:0]   prediction,
    output logic                                updated,
    output logic                                saturated,
    output logic signed [opl_pkg::WEIGHT_W-1:0] weight_value
);
    import opl_pkg::*;

    localparam int LANES = FEATURE_COUNT + 1;

    logic [RATE_W-1:0]          rate_reg;
    logic                       s1_valid_reg, s1_valid_next;
    logic [OP_W-1:0]            s1_op_reg;
    logic                       s1_pos_reg;
    logic [IDX_W-1:0]           s1_idx_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [PRED_W-1:0]   pred_reg, pred_next;
    logic                       upd_reg, upd_next;
    logic                       sat_reg, sat_next;
    logic signed [WEIGHT_W-1:0] wval_reg, wval_next;

    logic                       s1_adv, s1_mod, load, miss, any_clip;
    logic signed [FEAT_W-1:0]   feats [MAX_FEATURES];
    logic signed [PROD_W-1:0]   products [LANES];
    logic signed [WEIGHT_W-1:0] weights [LANES];
    logic [LANES-1:0]           clips;
    logic signed [WEIGHT_W-1:0] sel_weight;
    score_sign_t                sign;
    lane_ctrl_t                 ctrl;

    assign feats[0] = feature_0;
    assign feats[1] = feature_1;
    assign feats[2] = feature_2;
    assign feats[3] = feature_3;
    assign feats[4] = feature_4;
    assign feats[5] = feature_5;
    assign feats[6] = feature_6;
    assign feats[7] = feature_7;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_mod   = (s1_op_reg == OP_TRAIN) || (s1_op_reg == OP_CLEAR);
    assign in_ready = !s1_valid_reg || (s1_adv && !s1_mod);
    assign load     = in_valid && in_ready;

    assign miss     = s1_pos_reg ? !sign.pos : !sign.neg;
    assign any_clip = |clips;

    assign ctrl.load     = load;
    assign ctrl.commit   = s1_adv && (s1_op_reg == OP_TRAIN) && miss;
    assign ctrl.clear    = s1_adv && (s1_op_reg == OP_CLEAR);
    assign ctrl.positive = s1_pos_reg;

    opl_lane u_bias_lane (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .feature       (BIAS_FEATURE),
        .learning_rate (rate_reg),
        .product       (products[0]),
        .weight        (weights[0]),
        .clip          (clips[0])
    );

    for (genvar g = 1; g < LANES; g++)
    begin : g_lane
        opl_lane u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .feature       (feats[g-1]),
            .learning_rate (rate_reg),
            .product       (products[g]),
            .weight        (weights[g]),
            .clip          (clips[g])
        );
    end

    opl_merge #(
        .LANES (LANES)
    ) u_merge (
        .products (products),
        .sign     (sign)
    );

    always_comb
    begin
        sel_weight = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (s1_idx_reg == IDX_W'(i))
                sel_weight = weights[i];
        end
    end

    always_comb
    begin
        pred_next = PRED_ZERO;
        upd_next  = 1'b0;
        sat_next  = 1'b0;
        wval_next = '0;
        unique case (s1_op_reg)
            OP_TRAIN:
            begin
                pred_next = sign.pos ? PRED_POS : (sign.neg ? PRED_NEG : PRED_ZERO);
                upd_next  = miss;
                sat_next  = miss && any_clip;
            end
            OP_PREDICT:
            begin
                pred_next = sign.pos ? PRED_POS : (sign.neg ? PRED_NEG : PRED_ZERO);
            end
            OP_READ:
            begin
                wval_next = sel_weight;
            end
            OP_CLEAR:
            begin
                wval_next = '0;
            end
            default:
            begin
                wval_next = '0;
            end
        endcase
    end

    always_comb
    begin
        if (load)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= RATE_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                rate_reg <= cfg_wr_data;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_op_reg  <= op;
            s1_pos_reg <= label_positive;
            s1_idx_reg <= weight_index;
        end
        if (s1_adv)
        begin
            pred_reg <= pred_next;
            upd_reg  <= upd_next;
            sat_reg  <= sat_next;
            wval_reg <= wval_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign prediction   = pred_reg;
    assign updated      = upd_reg;
    assign saturated    = sat_reg;
    assign weight_value = wval_reg;

endmodule

@@ bench/opl_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the online perceptron learner: keeps its own copy of the
// weights and rate, predicts one result per accepted request, compares results.
// Depends on opl_pkg.
module opl_result_checker #(
    parameter int FEATURE_COUNT = opl_pkg::MAX_FEATURES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [opl_pkg::RATE_W-1:0]          cfg_wr_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [opl_pkg::OP_W-1:0]            op,
    input  logic                                label_positive,
    input  logic [opl_pkg::IDX_W-1:0]           weight_index,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_0,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_1,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_2,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_3,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_4,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_5,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_6,
    input  logic signed [opl_pkg::FEAT_W-1:0]   feature_7,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [opl_pkg::PRED_W-1:0]   prediction,
    input  logic                                updated,
    input  logic                                saturated,
    input  logic signed [opl_pkg::WEIGHT_W-1:0] weight_value,
    output int                                  mismatch_count,
    output int                                  pending_count
);
    import opl_pkg::*;

    typedef struct packed {
        logic signed [PRED_W-1:0]   prediction;
        logic                       updated;
        logic                       saturated;
        logic signed [WEIGHT_W-1:0] weight_value;
    } learner_result_t;

    typedef logic signed [FEAT_W-1:0] sample_t [MAX_FEATURES];

    localparam longint WEIGHT_HI = 64'sd2147483647;
    localparam longint WEIGHT_LO = -64'sd2147483647 - 64'sd1;

    logic signed [WEIGHT_W-1:0] shadow_weights [MAX_FEATURES+1];
    logic [RATE_W-1:0]          shadow_rate;
    learner_result_t            expected_results [$];
    int                         result_number;

    function automatic learner_result_t score_and_learn(
        input logic [OP_W-1:0]  req_op,
        input logic             req_positive,
        input logic [IDX_W-1:0] req_index,
        input sample_t          req_sample
    );
        learner_result_t res;
        longint          feat [MAX_FEATURES+1];
        longint          score;
        longint          rate_l;
        longint          delta;
        longint          next_w;
        logic            miss;
        res    = '0;
        score  = 64'sd0;
        rate_l = longint'(shadow_rate);
        feat[0] = longint'(BIAS_FEATURE);
        for (int i = 1; i <= MAX_FEATURES; i++)
        begin
            feat[i] = longint'(req_sample[i-1]);
        end
        if (req_op == OP_TRAIN || req_op == OP_PREDICT)
        begin
            for (int i = 0; i <= FEATURE_COUNT; i++)
            begin
                score += longint'(shadow_weights[i]) * feat[i];
            end
            res.prediction = (score > 0) ? PRED_POS : ((score < 0) ? PRED_NEG : PRED_ZERO);
        end
        case (req_op)
            OP_TRAIN:
            begin
                miss = req_positive ? (score <= 0) : (score >= 0);
                if (miss)
                begin
                    res.updated = 1'b1;
                    for (int i = 0; i <= FEATURE_COUNT; i++)
                    begin
                        delta  = rate_l * feat[i];
                        next_w = req_positive ? longint'(shadow_weights[i]) + delta
                                              : longint'(shadow_weights[i]) - delta;
                        if (next_w > WEIGHT_HI)
                        begin
                            next_w        = WEIGHT_HI;
                            res.saturated = 1'b1;
                        end
                        else if (next_w < WEIGHT_LO)
                        begin
                            next_w        = WEIGHT_LO;
                            res.saturated = 1'b1;
                        end
                        shadow_weights[i] = next_w[WEIGHT_W-1:0];
                    end
                end
            end
            OP_READ:
            begin
                if (req_index <= FEATURE_COUNT)
                begin
                    res.weight_value = shadow_weights[req_index];
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i <= MAX_FEATURES; i++)
                begin
                    shadow_weights[i] = '0;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 50)
        begin
            $display("[%0t] result %0d: %s got %h expected %h",
                     $time, result_number, field, got, want);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        learner_result_t want;
        sample_t         sample;
        if (!rst_n)
        begin
            for (int i = 0; i <= MAX_FEATURES; i++)
            begin
                shadow_weights[i] = '0;
            end
            shadow_rate = RATE_RESET;
            expected_results.delete();
            pending_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with no request, weight_value", weight_value, '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (prediction !== want.prediction)
                        report_mismatch("prediction", 32'(prediction), 32'(want.prediction));
                    if (updated !== want.updated)
                        report_mismatch("updated", 32'(updated), 32'(want.updated));
                    if (saturated !== want.saturated)
                        report_mismatch("saturated", 32'(saturated), 32'(want.saturated));
                    if (weight_value !== want.weight_value)
                        report_mismatch("weight_value", weight_value, want.weight_value);
                end
                result_number++;
            end
            if (in_valid && in_ready)
            begin
                sample = '{feature_0, feature_1, feature_2, feature_3,
                           feature_4, feature_5, feature_6, feature_7};
                expected_results.push_back(
                    score_and_learn(op, label_positive, weight_index, sample));
            end
            if (cfg_wr_en)
            begin
                shadow_rate = cfg_wr_data;
            end
            pending_count = expected_results.size();
        end
    end

endmodule

@@ bench/tb_online_perceptron_learner.sv @@
`timescale 1ns / 1ps
// Testbench top for the online perceptron learner: clock, reset, request and
// result-side stimulus, rate writes, watchdog and verdict.
// Depends on opl_pkg, online_perceptron_learner and opl_result_checker.
module tb_online_perceptron_learner;
    import opl_pkg::*;

    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef logic signed [FEAT_W-1:0] sample_t [MAX_FEATURES];

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [RATE_W-1:0]      cfg_wr_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [OP_W-1:0]        op;
    logic                   label_positive;
    logic [IDX_W-1:0]       weight_index;
    logic signed [FEAT_W-1:0] feature_0, feature_1, feature_2, feature_3;
    logic signed [FEAT_W-1:0] feature_4, feature_5, feature_6, feature_7;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [PRED_W-1:0]   prediction;
    logic                       updated;
    logic                       saturated;
    logic signed [WEIGHT_W-1:0] weight_value;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int idle_cycles    = 0;
    int mismatch_count;
    int pending_count;
    int target_weights [MAX_FEATURES+1];

    always #10 clk = ~clk;

    online_perceptron_learner dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .label_positive (label_positive),
        .weight_index   (weight_index),
        .feature_0      (feature_0),
        .feature_1      (feature_1),
        .feature_2      (feature_2),
        .feature_3      (feature_3),
        .feature_4      (feature_4),
        .feature_5      (feature_5),
        .feature_6      (feature_6),
        .feature_7      (feature_7),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .prediction     (prediction),
        .updated        (updated),
        .saturated      (saturated),
        .weight_value   (weight_value)
    );

    opl_result_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .label_positive (label_positive),
        .weight_index   (weight_index),
        .feature_0      (feature_0),
        .feature_1      (feature_1),
        .feature_2      (feature_2),
        .feature_3      (feature_3),
        .feature_4      (feature_4),
        .feature_5      (feature_5),
        .feature_6      (feature_6),
        .feature_7      (feature_7),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .prediction     (prediction),
        .updated        (updated),
        .saturated      (saturated),
        .weight_value   (weight_value),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    function automatic logic signed [FEAT_W-1:0] pick_feature();
        int v;
        case ($urandom_range(9))
            0:       v = 32767;
            1:       v = -32768;
            2:       v = 0;
            3, 4:    v = $urandom_range(1024) - 512;
            default: v = $urandom();
        endcase
        return v[FEAT_W-1:0];
    endfunction

    function automatic sample_t uniform_sample(input logic signed [FEAT_W-1:0] v);
        sample_t s;
        foreach (s[i])
        begin
            s[i] = v;
        end
        return s;
    endfunction

    // label from a hidden separating plane, so training mostly converges
    function automatic logic target_label(input sample_t s);
        longint acc;
        acc = longint'(target_weights[0]) * 256;
        foreach (s[i])
        begin
            acc += longint'(target_weights[i+1]) * s[i];
        end
        return acc > 0;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [OP_W-1:0] r_op, input logic r_label,
                                input logic [IDX_W-1:0] r_idx, input sample_t r_feat);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        op             <= r_op;
        label_positive <= r_label;
        weight_index   <= r_idx;
        feature_0      <= r_feat[0];
        feature_1      <= r_feat[1];
        feature_2      <= r_feat[2];
        feature_3      <= r_feat[3];
        feature_4      <= r_feat[4];
        feature_5      <= r_feat[5];
        feature_6      <= r_feat[6];
        feature_7      <= r_feat[7];
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random_phase(input int phase);
        sample_t          s;
        int               pick;
        logic [OP_W-1:0]  r_op;
        logic             r_label;
        logic [IDX_W-1:0] r_idx;
        foreach (target_weights[i])
        begin
            target_weights[i] = $urandom_range(512) - 256;
        end
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (phase == 0 && n == 60)
                hold_requests++;
            if (phase == 5 && n == 100)
                wait_for_results();
            foreach (s[i])
            begin
                s[i] = pick_feature();
            end
            pick    = $urandom_range(99);
            r_idx   = IDX_W'($urandom_range(15));
            r_label = 1'($urandom_range(1));
            if (pick < 50)
            begin
                r_op = OP_TRAIN;
                if ($urandom_range(9) < 8)
                    r_label = target_label(s);
            end
            else if (pick < 75)
            begin
                r_op = OP_PREDICT;
            end
            else if (pick < 97)
            begin
                r_op = OP_READ;
                if ($urandom_range(9) < 7)
                    r_idx = IDX_W'($urandom_range(MAX_FEATURES));
            end
            else
            begin
                r_op = OP_CLEAR;
            end
            send_request(r_op, r_label, r_idx, s);
        end
    endtask

    // result side: random stalls, plus long hold-offs on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        sample_t           s;
        logic [RATE_W-1:0] phase_rates [PHASE_COUNT];
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        in_valid       = 1'b0;
        op             = OP_PREDICT;
        label_positive = 1'b0;
        weight_index   = '0;
        feature_0      = '0;
        feature_1      = '0;
        feature_2      = '0;
        feature_3      = '0;
        feature_4      = '0;
        feature_5      = '0;
        feature_6      = '0;
        feature_7      = '0;
        phase_rates = '{16'h0000, 16'h0001, 16'h0100, 16'hFFFF,
                        16'h8000, 16'h0000, 16'h0000, 16'h1000};
        phase_rates[5] = RATE_W'($urandom());
        phase_rates[6] = RATE_W'($urandom());
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset rate, zero score, saturation at the upper bound, read range
        send_request(OP_READ, 1'b0, 4'd0, uniform_sample(16'sh0000));
        send_request(OP_PREDICT, 1'b1, 4'd3, uniform_sample(16'sh0000));
        send_request(OP_TRAIN, 1'b1, 4'd0, uniform_sample(16'sh7FFF));
        send_request(OP_PREDICT, 1'b0, 4'd0, uniform_sample(16'sh7FFF));
        s = uniform_sample(16'sh8000);
        s[0] = 16'sh7FFF;
        send_request(OP_TRAIN, 1'b1, 4'd15, s);
        send_request(OP_READ, 1'b1, 4'd1, uniform_sample(16'sh7FFF));
        send_request(OP_READ, 1'b0, 4'd8, uniform_sample(16'sh0000));
        send_request(OP_READ, 1'b0, 4'd9, uniform_sample(16'sh0000));
        send_request(OP_READ, 1'b1, 4'd15, uniform_sample(16'sh8000));
        send_request(OP_PREDICT, 1'b0, 4'd0, uniform_sample(16'sh8000));
        send_request(OP_TRAIN, 1'b0, 4'd0, uniform_sample(16'sh7FFF));
        send_request(OP_CLEAR, 1'b1, 4'd15, uniform_sample(16'sh7FFF));
        send_request(OP_READ, 1'b0, 4'd0, uniform_sample(16'sh0000));
        send_request(OP_TRAIN, 1'b0, 4'd0, uniform_sample(16'sh8000));
        send_request(OP_TRAIN, 1'b0, 4'd0, uniform_sample(16'sh8000));
        send_request(OP_PREDICT, 1'b1, 4'd15, uniform_sample(16'sh0000));
        send_request(OP_TRAIN, 1'b1, 4'd0, uniform_sample(16'sh0000));
        send_request(OP_READ, 1'b0, 4'd0, uniform_sample(16'sh0000));
        send_request(OP_READ, 1'b1, 4'd5, uniform_sample(16'sh0000));
        send_request(OP_CLEAR, 1'b0, 4'd0, uniform_sample(16'sh0000));
        wait_for_results();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase
            write_rate(phase_rates[phase]);
            run_random_phase(phase);
            wait_for_results();
        end

        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ online_perceptron_learner.f @@
rtl/opl_pkg.sv
rtl/opl_lane.sv
rtl/opl_merge.sv
rtl/online_perceptron_learner.sv
bench/opl_result_checker.sv
bench/tb_online_perceptron_learner.sv
